FILE: rtl/clbt_pkg.sv
// shared types and constants for the cell list bucket table
`timescale 1ns / 1ps

package clbt_pkg;

   localparam int NUM_CELLS     = 512;
   localparam int CELL_CAPACITY = 16;

   localparam int CELL_W  = $clog2(NUM_CELLS);
   localparam int SLOT_W  = $clog2(CELL_CAPACITY);
   localparam int CNT_W   = $clog2(CELL_CAPACITY + 1);
   localparam int SADDR_W = CELL_W + SLOT_W;
   localparam int ID_W    = 12;
   localparam int ACT_W   = 3;
   localparam int STAT_W  = 2;

   // action codes
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
   localparam logic [ACT_W-1:0] ACT_MOVE   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_SWAP   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic              we;
      logic [CELL_W-1:0] waddr;
      logic [CNT_W-1:0]  wdata;
      logic [CELL_W-1:0] raddr;
   } cnt_port_type;

   typedef struct packed {
      logic               we;
      logic [SADDR_W-1:0] waddr;
      logic [ID_W-1:0]    wdata;
      logic [SADDR_W-1:0] raddr;
   } slot_port_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ID_W-1:0]   read_id;
      logic [CNT_W-1:0]  count;
   } res_type;

endpackage

FILE: rtl/clbt_ram.sv
// simple dual port ram with registered read
`timescale 1ns / 1ps

module clbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/clbt_seq.sv
// sequencer: clear sweep, count fetch, insert, shared id compare for search, erase, append and slot read steps
`timescale 1ns / 1ps

module clbt_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [clbt_pkg::ACT_W-1:0]  req_action,
   input  logic [clbt_pkg::ID_W-1:0]   req_particle_id,
   input  logic [clbt_pkg::ID_W-1:0]   req_other_id,
   input  logic [clbt_pkg::CELL_W-1:0] req_cell_req,
   input  logic [clbt_pkg::CELL_W-1:0] req_other_cell,
   input  logic [clbt_pkg::SLOT_W-1:0] req_slot,
   input  logic [clbt_pkg::CNT_W-1:0]  cnt_rdata,
   input  logic [clbt_pkg::ID_W-1:0]   slot_rdata,
   output clbt_pkg::cnt_port_type      cnt_port,
   output clbt_pkg::slot_port_type     slot_port,
   output logic                        res_valid,
   output clbt_pkg::res_type           res,
   input  logic                        res_take
);

   import clbt_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CNT_A,
      S_CNT_B,
      S_DISPATCH,
      S_SRCH_A,
      S_SRCH_B,
      S_SWAP_WR,
      S_ER_RD,
      S_ER_WR,
      S_APPEND,
      S_READ_WAIT,
      S_FIN
   } state_type;

   state_type         state_ff, state_in;
   logic [CELL_W-1:0] clr_ff, clr_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic              cmp_vld_ff, cmp_vld_in;

   logic [ACT_W-1:0]  act_ff, act_in;
   logic [ID_W-1:0]   id_a_ff, id_a_in;
   logic [ID_W-1:0]   id_b_ff, id_b_in;
   logic [CELL_W-1:0] ca_ff, ca_in;
   logic [CELL_W-1:0] cb_ff, cb_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  cnt_a_ff, cnt_a_in;
   logic [CNT_W-1:0]  cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [SLOT_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [SLOT_W-1:0] pos_a_ff, pos_a_in;
   logic [SLOT_W-1:0] pos_b_ff, pos_b_in;
   logic [SLOT_W-1:0] er_idx_ff, er_idx_in;
   res_type           res_ff, res_in;

   logic              srch_b;
   logic [CELL_W-1:0] srch_cell;
   logic [ID_W-1:0]   srch_key;
   logic [CNT_W-1:0]  srch_n;
   logic              srch_issue;
   logic              srch_hit;
   logic [CNT_W-1:0]  er_next;

   // shared compare unit
   assign srch_b     = (state_ff == S_SRCH_B);
   assign srch_cell  = srch_b ? cb_ff : ca_ff;
   assign srch_key   = srch_b ? id_b_ff : id_a_ff;
   assign srch_n     = srch_b ? cnt_b_ff : cnt_a_ff;
   assign srch_issue = (idx_ff < srch_n);
   assign srch_hit   = cmp_vld_ff && (slot_rdata == srch_key);
   assign er_next    = CNT_W'(er_idx_ff) + CNT_W'(1);

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      clr_rsp_in = clr_rsp_ff;
      cmp_vld_in = cmp_vld_ff;
      act_in     = act_ff;
      id_a_in    = id_a_ff;
      id_b_in    = id_b_ff;
      ca_in      = ca_ff;
      cb_in      = cb_ff;
      slot_in    = slot_ff;
      cnt_a_in   = cnt_a_ff;
      cnt_b_in   = cnt_b_ff;
      idx_in     = idx_ff;
      cmp_idx_in = cmp_idx_ff;
      pos_a_in   = pos_a_ff;
      pos_b_in   = pos_b_ff;
      er_idx_in  = er_idx_ff;
      res_in     = res_ff;
      cnt_port       = '0;
      cnt_port.raddr = ca_ff;
      slot_port       = '0;
      slot_port.raddr = {srch_cell, idx_ff[SLOT_W-1:0]};

      unique case (state_ff)
         S_CLEAR: begin
            cnt_port.we    = 1'b1;
            cnt_port.waddr = clr_ff;
            cnt_port.wdata = '0;
            clr_in         = clr_ff + CELL_W'(1);
            if (clr_ff == CELL_W'(NUM_CELLS - 1)) begin
               res_in   = '{status: ST_OK, read_id: '0, count: '0};
               state_in = clr_rsp_ff ? S_FIN : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               id_a_in  = req_particle_id;
               id_b_in  = req_other_id;
               ca_in    = req_cell_req;
               cb_in    = req_other_cell;
               slot_in  = req_slot;
               state_in = S_CNT_A;
            end
         end
         S_CNT_A: begin
            cnt_port.raddr = ca_ff;
            state_in       = S_CNT_B;
         end
         S_CNT_B: begin
            cnt_port.raddr = cb_ff;
            cnt_a_in       = cnt_rdata;
            state_in       = S_DISPATCH;
         end
         S_DISPATCH: begin
            cnt_b_in   = cnt_rdata;
            idx_in     = '0;
            cmp_vld_in = 1'b0;
            res_in     = '{status: ST_OK, read_id: '0, count: cnt_a_ff};
            state_in   = S_FIN;
            unique case (act_ff)
               ACT_CLEAR: begin
                  clr_in     = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = S_CLEAR;
               end
               ACT_INSERT: begin
                  if (cnt_a_ff >= CNT_W'(CELL_CAPACITY)) begin
                     res_in.status = ST_FULL;
                  end else begin
                     slot_port.we    = 1'b1;
                     slot_port.waddr = {ca_ff, cnt_a_ff[SLOT_W-1:0]};
                     slot_port.wdata = id_a_ff;
                     cnt_port.we     = 1'b1;
                     cnt_port.waddr  = ca_ff;
                     cnt_port.wdata  = cnt_a_ff + CNT_W'(1);
                     res_in.count    = cnt_a_ff + CNT_W'(1);
                  end
               end
               ACT_MOVE: begin
                  if (ca_ff != cb_ff) begin
                     state_in = S_SRCH_A;
                  end
               end
               ACT_SWAP: begin
                  state_in = S_SRCH_A;
               end
               ACT_READ: begin
                  if (CNT_W'(slot_ff) < cnt_a_ff) begin
                     slot_port.raddr = {ca_ff, slot_ff};
                     state_in        = S_READ_WAIT;
                  end else begin
                     res_in.status = ST_EMPTY;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SRCH_A, S_SRCH_B: begin
            slot_port.raddr = {srch_cell, idx_ff[SLOT_W-1:0]};
            if (srch_hit) begin
               cmp_vld_in = 1'b0;
               idx_in     = '0;
               if (srch_b) begin
                  pos_b_in = cmp_idx_ff;
                  state_in = S_SWAP_WR;
               end else begin
                  pos_a_in  = cmp_idx_ff;
                  er_idx_in = cmp_idx_ff;
                  if (act_ff == ACT_SWAP) begin
                     state_in = S_SRCH_B;
                  end else if (cnt_b_ff >= CNT_W'(CELL_CAPACITY)) begin
                     res_in   = '{status: ST_FULL, read_id: '0, count: cnt_a_ff};
                     state_in = S_FIN;
                  end else begin
                     state_in = S_ER_RD;
                  end
               end
            end else if (!srch_issue) begin
               cmp_vld_in = 1'b0;
               res_in     = '{status: ST_NOT_FOUND, read_id: '0, count: cnt_a_ff};
               state_in   = S_FIN;
            end else begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = idx_ff[SLOT_W-1:0];
               idx_in     = idx_ff + CNT_W'(1);
            end
         end
         S_SWAP_WR: begin
            slot_port.we    = 1'b1;
            slot_port.waddr = {cb_ff, pos_b_ff};
            slot_port.wdata = id_a_ff;
            er_idx_in       = pos_a_ff;
            state_in        = S_ER_RD;
         end
         S_ER_RD: begin
            slot_port.raddr = {ca_ff, er_next[SLOT_W-1:0]};
            if (er_next < cnt_a_ff) begin
               state_in = S_ER_WR;
            end else begin
               cnt_port.we    = 1'b1;
               cnt_port.waddr = ca_ff;
               cnt_port.wdata = cnt_a_ff - CNT_W'(1);
               res_in = '{status: ST_OK, read_id: '0, count: cnt_a_ff - CNT_W'(1)};
               state_in = (act_ff == ACT_MOVE) ? S_APPEND : S_FIN;
            end
         end
         S_ER_WR: begin
            slot_port.we    = 1'b1;
            slot_port.waddr = {ca_ff, er_idx_ff};
            slot_port.wdata = slot_rdata;
            er_idx_in       = er_next[SLOT_W-1:0];
            state_in        = S_ER_RD;
         end
         S_APPEND: begin
            slot_port.we    = 1'b1;
            slot_port.waddr = {cb_ff, cnt_b_ff[SLOT_W-1:0]};
            slot_port.wdata = id_a_ff;
            cnt_port.we     = 1'b1;
            cnt_port.waddr  = cb_ff;
            cnt_port.wdata  = cnt_b_ff + CNT_W'(1);
            state_in        = S_FIN;
         end
         S_READ_WAIT: begin
            res_in   = '{status: ST_OK, read_id: slot_rdata, count: cnt_a_ff};
            state_in = S_FIN;
         end
         S_FIN: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_rsp_ff <= clr_rsp_in;
         cmp_vld_ff <= cmp_vld_in;
      end
      act_ff     <= act_in;
      id_a_ff    <= id_a_in;
      id_b_ff    <= id_b_in;
      ca_ff      <= ca_in;
      cb_ff      <= cb_in;
      slot_ff    <= slot_in;
      cnt_a_ff   <= cnt_a_in;
      cnt_b_ff   <= cnt_b_in;
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      pos_a_ff   <= pos_a_in;
      pos_b_ff   <= pos_b_in;
      er_idx_ff  <= er_idx_in;
      res_ff     <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_FIN);
   assign res       = res_ff;

   // a cell count never goes past capacity
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_port.we |-> (cnt_port.wdata <= CNT_W'(CELL_CAPACITY)))
      else $error("cell count write beyond capacity");

   // erase write always uses the slot read just before
   a_erase_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ER_WR) |-> ($past(state_ff) == S_ER_RD))
      else $error("erase write without preceding read");

   // a hit in the first search lies below the cell's count
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH_A && srch_hit) |-> (CNT_W'(cmp_idx_ff) < cnt_a_ff))
      else $error("search hit beyond cell count");

   // a finished result holds until the output stage takes it
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_take) |=> (res_valid && $stable(res_ff)))
      else $error("pending result changed");

endmodule

FILE: rtl/cell_list_bucket_table.sv
// top level of the cell list bucket table
`timescale 1ns / 1ps

// Keeps an ordered list of up to 16 particle ids for each of 512 cells, with
// actions clear all, insert, move, swap-and-delete and read slot, each giving
// one transaction on the rsp_ channel (status, read id, count of cell_req after
// the action). One request is worked at a time; req_ready is low while it runs.
// A single shared id comparator walks the slots of a cell one per cycle, and
// the order-keeping erase shifts one slot at a time, by a read state and then
// a write state, through the slot ram's single read and write ports. A move
// is a search and then an erase; swap-and-delete is two searches plus an
// erase. Clear all writes one cell count per cycle, and after reset the block
// runs the same clearing pass over the count ram before req_ready rises.
// A finished transaction waits in the rsp_ output register, so the next
// request can be accepted before the previous result is taken.

module cell_list_bucket_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [clbt_pkg::ACT_W-1:0]  req_action,
   input  logic [clbt_pkg::ID_W-1:0]   req_particle_id,
   input  logic [clbt_pkg::ID_W-1:0]   req_other_id,
   input  logic [clbt_pkg::CELL_W-1:0] req_cell_req,
   input  logic [clbt_pkg::CELL_W-1:0] req_other_cell,
   input  logic [clbt_pkg::SLOT_W-1:0] req_slot,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [clbt_pkg::STAT_W-1:0] rsp_status,
   output logic [clbt_pkg::ID_W-1:0]   rsp_read_id,
   output logic [4:0]                  rsp_cell_count
);

   import clbt_pkg::*;

   cnt_port_type     cnt_port;
   slot_port_type    slot_port;
   logic [CNT_W-1:0] cnt_rdata;
   logic [ID_W-1:0]  slot_rdata;
   logic             res_valid;
   res_type          res;
   logic             res_take;

   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_ff;

   // sequencer with the shared search comparator
   clbt_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_particle_id (req_particle_id),
      .req_other_id    (req_other_id),
      .req_cell_req    (req_cell_req),
      .req_other_cell  (req_other_cell),
      .req_slot        (req_slot),
      .cnt_rdata       (cnt_rdata),
      .slot_rdata      (slot_rdata),
      .cnt_port        (cnt_port),
      .slot_port       (slot_port),
      .res_valid       (res_valid),
      .res             (res),
      .res_take        (res_take)
   );

   // per-cell entry counts, cleared by the sweep after reset
   clbt_ram #(
      .WIDTH (CNT_W),
      .DEPTH (NUM_CELLS)
   ) u_cnt_ram (
      .clock (clock),
      .we    (cnt_port.we),
      .waddr (cnt_port.waddr),
      .wdata (cnt_port.wdata),
      .raddr (cnt_port.raddr),
      .rdata (cnt_rdata)
   );

   // slot store, addressed {cell, slot}; only data from slots below the count is used
   clbt_ram #(
      .WIDTH (ID_W),
      .DEPTH (NUM_CELLS * CELL_CAPACITY)
   ) u_slot_ram (
      .clock (clock),
      .we    (slot_port.we),
      .waddr (slot_port.waddr),
      .wdata (slot_port.wdata),
      .raddr (slot_port.raddr),
      .rdata (slot_rdata)
   );

   // output register: take a new result when empty or being drained
   assign res_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid && res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_read_id    = rsp_ff.read_id;
   assign rsp_cell_count = 5'(rsp_ff.count);

endmodule
